// File: rtl/core/stream_dma_buffer_cache_defines.svh
// Assertion macros used by the checker file.
`ifndef STREAM_DMA_BUFFER_CACHE_DEFINES_SVH
`define STREAM_DMA_BUFFER_CACHE_DEFINES_SVH

// Clocked on clk and disabled while rst_n is low.
`define SDBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked on clk and also checked during reset.
`define SDBC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/sdbc_pkg.sv
`timescale 1ns / 1ps
package sdbc_pkg;

    localparam logic [15:0] BUFFER_SIZE_RESET = 16'd1024;

    typedef struct packed {
        logic        mode;
        logic [31:0] addr;
        logic [15:0] len;
    } in_t;

    typedef struct packed {
        logic        hit;
        logic        no_buffer;
        logic [5:0]  buffer_index;
        logic [15:0] offset;
        logic        dma_start;
        logic [31:0] dma_addr;
        logic [6:0]  dma_tag;
        logic [6:0]  freed_count;
    } out_t;

    typedef struct packed {
        logic load;
        logic adv;
        logic hit;
        logic nobuf;
        logic miss_wr;
        logic miss_lnk;
        logic free1;
        logic tfl2;
        logic tick_end;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic at_end;
        logic is_tick;
        logic below;
        logic fits;
        logic fl_empty;
        logic prev_valid;
        logic old;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/core/stream_dma_buffer_cache.sv
`timescale 1ns / 1ps
// Buffer pool that caches source reads: a data request (mode 0) is answered from an active
// buffer holding its range, or claims a free buffer and issues a fill DMA, or reports that
// no buffer is free; a tick (mode 1) reclaims buffers unused for more than one frame and
// advances the frame. One item is in work at a time and gives exactly one result item.
// The walk over the address-ordered active list sets the rate: each visited buffer costs a
// registered read of the buffer RAMs, then a compare. The next item is accepted only once
// the result of the last one is loaded into the output register; a result waiting there
// does not keep the next item from being accepted.
module stream_dma_buffer_cache #(
    parameter int NUM_BUFFERS = 16,
    parameter int MAX_PENDING = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [15:0]     cfg_data,
    input  logic            in_valid,
    output logic            in_stall,
    input  sdbc_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output sdbc_pkg::out_t  out_data
);

    sdbc_pkg::cmd_t cmd;
    sdbc_pkg::sts_t sts;

    sdbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    sdbc_datapath #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .MAX_PENDING (MAX_PENDING)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// File: rtl/core/sdbc_ram.sv
`timescale 1ns / 1ps
module sdbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/sdbc_ctrl.sv
`timescale 1ns / 1ps
module sdbc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sdbc_pkg::sts_t    sts,
    output sdbc_pkg::cmd_t    cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WALK = 4'd1;
    localparam logic [3:0] S_RCMP = 4'd2;
    localparam logic [3:0] S_TCMP = 4'd3;
    localparam logic [3:0] S_MISS = 4'd4;
    localparam logic [3:0] S_MWR  = 4'd5;
    localparam logic [3:0] S_MLNK = 4'd6;
    localparam logic [3:0] S_TFL2 = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                // The base, last-use and link RAMs read at the current entry every cycle; data shows up next cycle.
                if (sts.at_end)
                begin
                    if (sts.is_tick)
                    begin
                        cmd.tick_end = 1'b1;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MISS;
                    end
                end
                else
                begin
                    state_next = sts.is_tick ? S_TCMP : S_RCMP;
                end
            end
            S_RCMP:
            begin
                if (sts.below)
                begin
                    state_next = S_MISS;
                end
                else if (sts.fits)
                begin
                    cmd.hit    = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.adv    = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_MISS:
            begin
                if (sts.fl_empty)
                begin
                    cmd.nobuf  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MWR;
                end
            end
            S_MWR:
            begin
                cmd.miss_wr = 1'b1;
                state_next  = sts.prev_valid ? S_MLNK : S_DONE;
            end
            S_MLNK:
            begin
                cmd.miss_lnk = 1'b1;
                state_next   = S_DONE;
            end
            S_TCMP:
            begin
                if (sts.old)
                begin
                    cmd.free1  = 1'b1;
                    state_next = sts.fl_empty ? S_WALK : S_TFL2;
                end
                else
                begin
                    cmd.adv    = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_TFL2:
            begin
                cmd.tfl2   = 1'b1;
                state_next = S_WALK;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/sdbc_datapath.sv
`timescale 1ns / 1ps
module sdbc_datapath #(
    parameter int NUM_BUFFERS = 16,
    parameter int MAX_PENDING = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [15:0]     cfg_data,
    input  sdbc_pkg::in_t   in_data,
    input  sdbc_pkg::cmd_t  cmd,
    output sdbc_pkg::sts_t  sts,
    input  logic            out_stall,
    output logic            out_valid,
    output sdbc_pkg::out_t  out_data
);

    localparam int AW = $clog2(NUM_BUFFERS);
    localparam int LW = $clog2(NUM_BUFFERS + 1);
    localparam logic [LW-1:0] END_MARK = LW'(NUM_BUFFERS);
    localparam logic [6:0]    PEND_MAX = 7'(MAX_PENDING);

    logic [15:0]            size_reg;
    sdbc_pkg::in_t          req_reg;
    logic [LW-1:0]          cur_reg;
    logic [LW-1:0]          prev_reg;
    logic [LW-1:0]          steps_reg;
    logic [LW-1:0]          tmp_reg;
    logic [LW-1:0]          ahead_reg;
    logic [LW-1:0]          fhead_reg;
    logic [31:0]            frame_reg;
    logic [6:0]             pend_reg;
    logic [6:0]             freed_reg;
    sdbc_pkg::out_t         res_reg;
    sdbc_pkg::out_t         out_reg;
    logic                   out_valid_reg;
    logic [NUM_BUFFERS-1:0] fl_vld_reg;
    logic                   flrd_vld_reg;
    logic [AW-1:0]          flrd_idx_reg;

    logic [31:0]   base_rd;
    logic [31:0]   lu_rd;
    logic [LW-1:0] alink_rd;
    logic [LW-1:0] flink_ram_rd;
    logic [LW-1:0] fl_rd;

    logic          lu_we;
    logic [AW-1:0] lu_waddr;
    logic          al_we;
    logic [AW-1:0] al_waddr;
    logic [LW-1:0] al_wdata;
    logic          fl_we;
    logic [AW-1:0] fl_waddr;
    logic [LW-1:0] fl_wdata;

    // A free-list entry never written reads as its reset chain value, its index plus one.
    assign fl_rd = flrd_vld_reg ? flink_ram_rd : LW'(flrd_idx_reg) + LW'(1);

    assign lu_we    = cmd.hit | cmd.miss_wr;
    assign lu_waddr = cmd.hit ? cur_reg[AW-1:0] : fhead_reg[AW-1:0];

    assign al_we    = cmd.miss_wr | cmd.miss_lnk | (cmd.free1 & sts.prev_valid);
    assign al_waddr = cmd.miss_wr ? fhead_reg[AW-1:0] : prev_reg[AW-1:0];
    assign al_wdata = cmd.miss_wr ? cur_reg : (cmd.miss_lnk ? tmp_reg : alink_rd);

    assign fl_we    = cmd.free1 | cmd.tfl2;
    assign fl_waddr = cmd.free1 ? cur_reg[AW-1:0] : fhead_reg[AW-1:0];
    assign fl_wdata = cmd.free1 ? (sts.fl_empty ? END_MARK : fl_rd) : tmp_reg;

    sdbc_ram #(.WIDTH(32), .DEPTH(NUM_BUFFERS)) u_base (
        .clk   (clk),
        .we    (cmd.miss_wr),
        .waddr (fhead_reg[AW-1:0]),
        .wdata ({req_reg.addr[31:1], 1'b0}),
        .raddr (cur_reg[AW-1:0]),
        .rdata (base_rd)
    );

    sdbc_ram #(.WIDTH(32), .DEPTH(NUM_BUFFERS)) u_lastuse (
        .clk   (clk),
        .we    (lu_we),
        .waddr (lu_waddr),
        .wdata (frame_reg),
        .raddr (cur_reg[AW-1:0]),
        .rdata (lu_rd)
    );

    sdbc_ram #(.WIDTH(LW), .DEPTH(NUM_BUFFERS)) u_alink (
        .clk   (clk),
        .we    (al_we),
        .waddr (al_waddr),
        .wdata (al_wdata),
        .raddr (cur_reg[AW-1:0]),
        .rdata (alink_rd)
    );

    sdbc_ram #(.WIDTH(LW), .DEPTH(NUM_BUFFERS)) u_flink (
        .clk   (clk),
        .we    (fl_we),
        .waddr (fl_waddr),
        .wdata (fl_wdata),
        .raddr (fhead_reg[AW-1:0]),
        .rdata (flink_ram_rd)
    );

    assign sts.at_end     = (cur_reg >= END_MARK) || (steps_reg == END_MARK);
    assign sts.is_tick    = req_reg.mode;
    assign sts.below      = req_reg.addr < base_rd;
    assign sts.fits       = ({1'b0, req_reg.addr} + {17'b0, req_reg.len})
                            <= ({1'b0, base_rd} + {17'b0, size_reg});
    assign sts.fl_empty   = fhead_reg >= END_MARK;
    assign sts.prev_valid = prev_reg != END_MARK;
    assign sts.old        = ({1'b0, lu_rd} + 33'd1) < {1'b0, frame_reg};
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= sdbc_pkg::BUFFER_SIZE_RESET;
            ahead_reg     <= END_MARK;
            fhead_reg     <= '0;
            frame_reg     <= '0;
            pend_reg      <= '0;
            fl_vld_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_data;
            end
            if (fl_we)
            begin
                fl_vld_reg[fl_waddr] <= 1'b1;
            end
            if (cmd.miss_wr)
            begin
                fhead_reg <= fl_rd;
                if (!sts.prev_valid)
                begin
                    ahead_reg <= fhead_reg;
                end
                pend_reg <= (pend_reg < PEND_MAX) ? pend_reg + 7'd1 : PEND_MAX;
            end
            if (cmd.free1)
            begin
                if (!sts.prev_valid)
                begin
                    ahead_reg <= alink_rd;
                end
                if (sts.fl_empty)
                begin
                    fhead_reg <= cur_reg;
                end
            end
            if (cmd.tick_end)
            begin
                pend_reg  <= '0;
                frame_reg <= frame_reg + 32'd1;
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        flrd_vld_reg <= fl_vld_reg[fhead_reg[AW-1:0]];
        flrd_idx_reg <= fhead_reg[AW-1:0];
        if (cmd.load)
        begin
            req_reg   <= in_data;
            cur_reg   <= ahead_reg;
            prev_reg  <= END_MARK;
            steps_reg <= '0;
            freed_reg <= '0;
            res_reg   <= '0;
        end
        if (cmd.adv)
        begin
            prev_reg  <= cur_reg;
            cur_reg   <= alink_rd;
            steps_reg <= steps_reg + LW'(1);
        end
        if (cmd.hit)
        begin
            res_reg.hit          <= 1'b1;
            res_reg.buffer_index <= 6'(cur_reg[AW-1:0]);
            res_reg.offset       <= 16'(req_reg.addr - base_rd);
        end
        if (cmd.nobuf)
        begin
            res_reg.no_buffer <= 1'b1;
        end
        if (cmd.miss_wr)
        begin
            tmp_reg              <= fhead_reg;
            res_reg.buffer_index <= 6'(fhead_reg[AW-1:0]);
            res_reg.offset       <= {15'b0, req_reg.addr[0]};
            res_reg.dma_start    <= 1'b1;
            res_reg.dma_addr     <= {req_reg.addr[31:1], 1'b0};
            res_reg.dma_tag      <= pend_reg;
        end
        if (cmd.free1)
        begin
            tmp_reg   <= cur_reg;
            freed_reg <= freed_reg + 7'd1;
            cur_reg   <= alink_rd;
            steps_reg <= steps_reg + LW'(1);
        end
        if (cmd.tick_end)
        begin
            res_reg.freed_count <= freed_reg;
        end
        if (cmd.publish)
        begin
            out_reg <= res_reg;
        end
    end

endmodule

// File: rtl/core/sdbc_checker.sv
`timescale 1ns / 1ps
`include "stream_dma_buffer_cache_defines.svh"
module sdbc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input logic           out_valid,
    input logic           out_stall,
    input sdbc_pkg::out_t out_data
);

    // A result waiting on a stall holds its value.
    `SDBC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

    // An accepted item keeps the input side closed while it is worked on.
    `SDBC_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "second item taken during work")

    // A result is a hit, a fill, a no-buffer report or a tick, never two of them.
    `SDBC_ASSERT(a_one_kind, out_valid |-> !(out_data.hit && out_data.dma_start) && !(out_data.no_buffer && (out_data.hit || out_data.dma_start)), "result mixes kinds")

    // A fill always starts at an even address and the offset is only the low bit.
    `SDBC_ASSERT(a_fill_even, out_valid && out_data.dma_start |-> !out_data.dma_addr[0] && (out_data.offset[15:1] == 15'd0), "fill not aligned")

endmodule

bind stream_dma_buffer_cache sdbc_checker u_sdbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// File: bench/tb.sv
`timescale 1ns / 1ps
module tb;

    localparam int NB = 16;
    localparam int MAXP = 64;
    localparam int LIMIT = 2000000;

    // Software copy of the buffer pool; answers one item at a time.
    class pool_scoreboard;
        logic [31:0] base[NB];
        logic [31:0] used[NB];
        int          alink[NB];
        int          flink[NB];
        int          ahead;
        int          fhead;
        logic [31:0] frame;
        int          pending;
        logic [15:0] bsize;
        sdbc_pkg::out_t waiting[$];
        int          errors;
        int          hits;
        int          misses;
        int          refusals;
        int          ticks;
        int          checked;

        function new();
            for (int i = 0; i < NB; i++)
            begin
                flink[i] = i + 1;
                base[i] = '0;
                used[i] = '0;
                alink[i] = 0;
            end
            ahead = NB;
            fhead = 0;
            frame = '0;
            pending = 0;
            bsize = sdbc_pkg::BUFFER_SIZE_RESET;
            errors = 0;
        endfunction

        function int active_count();
            int n;
            int c;
            n = 0;
            c = ahead;
            while (c < NB && n < NB)
            begin
                n++;
                c = alink[c];
            end
            return n;
        endfunction

        function void note_item(sdbc_pkg::in_t it);
            sdbc_pkg::out_t r;
            int cur;
            int prev;
            int steps;
            int b;
            int nxt;
            int freed;
            logic [32:0] rend;
            r = '0;
            cur = ahead;
            prev = NB;
            steps = 0;
            if (it.mode)
            begin
                freed = 0;
                ticks++;
                while (cur < NB && steps < NB)
                begin
                    nxt = alink[cur];
                    if ({1'b0, used[cur]} + 33'd1 < {1'b0, frame})
                    begin
                        if (prev < NB)
                            alink[prev] = nxt;
                        else
                            ahead = nxt;
                        if (fhead < NB)
                        begin
                            flink[cur] = flink[fhead];
                            flink[fhead] = cur;
                        end
                        else
                        begin
                            fhead = cur;
                            flink[cur] = NB;
                        end
                        freed++;
                    end
                    else
                        prev = cur;
                    cur = nxt;
                    steps++;
                end
                r.freed_count = freed[6:0];
                pending = 0;
                frame = frame + 32'd1;
                waiting.push_back(r);
                return;
            end
            rend = {1'b0, it.addr} + {17'd0, it.len};
            while (cur < NB && steps < NB)
            begin
                if (it.addr < base[cur])
                    break;
                prev = cur;
                if (rend <= {1'b0, base[cur]} + {17'd0, bsize})
                begin
                    used[cur] = frame;
                    r.hit = 1'b1;
                    r.buffer_index = cur[5:0];
                    r.offset = 16'(it.addr - base[cur]);
                    hits++;
                    waiting.push_back(r);
                    return;
                end
                cur = alink[cur];
                steps++;
            end
            if (fhead >= NB)
            begin
                r.no_buffer = 1'b1;
                refusals++;
                waiting.push_back(r);
                return;
            end
            b = fhead;
            fhead = flink[b];
            if (prev < NB)
            begin
                alink[b] = alink[prev];
                alink[prev] = b;
            end
            else
            begin
                alink[b] = ahead;
                ahead = b;
            end
            base[b] = {it.addr[31:1], 1'b0};
            used[b] = frame;
            r.buffer_index = b[5:0];
            r.offset = {15'd0, it.addr[0]};
            r.dma_start = 1'b1;
            r.dma_addr = base[b];
            r.dma_tag = pending[6:0];
            if (pending < MAXP)
                pending++;
            misses++;
            waiting.push_back(r);
        endfunction

        function void check_result(sdbc_pkg::out_t got);
            sdbc_pkg::out_t e;
            checked++;
            if (waiting.size() == 0)
            begin
                $error("result with nothing expected: %p", got);
                errors++;
                return;
            end
            e = waiting.pop_front();
            if (got !== e)
            begin
                errors++;
                if (got.hit !== e.hit)
                    $error("hit: expected %0d, got %0d", e.hit, got.hit);
                if (got.no_buffer !== e.no_buffer)
                    $error("no_buffer: expected %0d, got %0d", e.no_buffer, got.no_buffer);
                if (got.buffer_index !== e.buffer_index)
                    $error("buffer_index: expected %0d, got %0d",
                           e.buffer_index, got.buffer_index);
                if (got.offset !== e.offset)
                    $error("offset: expected %0h, got %0h", e.offset, got.offset);
                if (got.dma_start !== e.dma_start)
                    $error("dma_start: expected %0d, got %0d", e.dma_start, got.dma_start);
                if (got.dma_addr !== e.dma_addr)
                    $error("dma_addr: expected %0h, got %0h", e.dma_addr, got.dma_addr);
                if (got.dma_tag !== e.dma_tag)
                    $error("dma_tag: expected %0d, got %0d", e.dma_tag, got.dma_tag);
                if (got.freed_count !== e.freed_count)
                    $error("freed_count: expected %0d, got %0d",
                           e.freed_count, got.freed_count);
            end
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  cfg_we;
    logic  [15:0] cfg_data;
    logic  in_valid;
    logic  in_stall;
    sdbc_pkg::in_t   in_data;
    logic  out_valid;
    logic  out_stall = 1'b0;
    sdbc_pkg::out_t  out_data;

    pool_scoreboard sb;
    int    send_idle;
    int    recv_stall;
    bit    hold_recv;
    int    cycles = 0;
    logic [31:0] region;

    stream_dma_buffer_cache dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: stall drawn each cycle; a long hold-off can be forced by the stimulus.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
        out_stall <= hold_recv || ($urandom_range(99) < recv_stall);
    end

    task automatic send_item(sdbc_pkg::in_t it);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(it);
        in_valid <= 1'b0;
        // The block stays busy after taking an item.
        @(posedge clk);
    endtask

    task automatic send_req(logic [31:0] a, logic [15:0] l);
        sdbc_pkg::in_t it;
        it.mode = 1'b0;
        it.addr = a;
        it.len = l;
        send_item(it);
    endtask

    task automatic send_tick();
        sdbc_pkg::in_t it;
        it.mode = 1'b1;
        it.addr = $urandom();
        it.len = 16'($urandom());
        send_item(it);
    endtask

    // Let everything drain, then allow the block to settle before a register write.
    task automatic drain();
        while (sb.waiting.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_size(logic [15:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.bsize = v;
    endtask

    // Mostly requests near a few hot regions so that hits, misses and reclaim all happen.
    task automatic random_item();
        int k;
        logic [31:0] a;
        k = $urandom_range(99);
        if (k < 8)
            send_tick();
        else if (k < 14)
            send_req($urandom(), 16'($urandom()));
        else
        begin
            a = region + ($urandom_range(7) * 32'd700) + $urandom_range(1500);
            send_req(a, (k < 80) ? 16'($urandom_range(64)) : 16'($urandom));
        end
    endtask

    task automatic random_phase(int n, int si, int rs);
        send_idle = si;
        recv_stall = rs;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(199) == 0)
                region = $urandom();
            random_item();
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        hold_recv = 1'b0;
        send_idle = 0;
        recv_stall = 0;
        region = 32'h0000_4000;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: miss, hit at odd offset, range end exactly at the buffer edge and one past.
        send_req(32'h0000_1001, 16'd10);
        send_req(32'h0000_1003, 16'd20);
        send_req(32'h0000_1000, 16'd1024);
        send_req(32'h0000_1001, 16'd1024);
        send_req(32'hFFFF_FFFF, 16'hFFFF);
        send_req(32'h0000_0000, 16'd0);
        send_req(32'hFFFF_FFFE, 16'd1);
        send_req(32'h8000_0000, 16'hFFFF);
        send_tick();
        send_tick();
        send_tick();
        // Exhaust the pool to reach the no-free-buffer case.
        for (int i = 0; i < 18; i++)
            send_req(32'h0010_0000 + i * 32'h1_0000, 16'd4);
        send_tick();
        send_tick();

        set_size(16'd2);
        random_phase(120, 0, 0);
        set_size(16'hFFFF);
        random_phase(120, 85, 0);
        set_size(16'd300);
        random_phase(120, 0, 85);
        set_size(16'd1024);
        random_phase(120, 17, 17);

        // Receiver holds off while the sender keeps offering items.
        send_idle = 0;
        recv_stall = 0;
        hold_recv = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_recv = 1'b0;
            end
            for (int i = 0; i < 30; i++)
                random_item();
        join
        // Sender waits for every result before continuing.
        while (sb.waiting.size() != 0)
            @(posedge clk);
        set_size(16'd5000);
        random_phase(130, 0, 0);

        while (sb.waiting.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Checked %0d results: %0d hits, %0d fills, %0d refusals, %0d ticks.",
                 sb.checked, sb.hits, sb.misses, sb.refusals, sb.ticks);
        $display("Buffer sizes 2 to 65535 with sender and receiver pressure; %0d active at end.",
                 sb.active_count());
        if (sb.errors == 0 && sb.waiting.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
